@@ src/srt_pkg.sv @@
`default_nettype none

package srt_pkg;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_FIND   = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [63:0] name_hi;
        logic [63:0] name_mid;
        logic [23:0] name_lo;
        logic [31:0] age;
        logic [63:0] phone_hi;
        logic [47:0] phone_lo;
    } t_rec;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_TOP,
        IDX_SLOT,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_NEW_UP,
        WR_NEW_0
    } t_wr_op;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_NEW_UP,
        RES_NEW_0,
        RES_HERE,
        RES_ERR
    } t_res_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic    load;
        logic    emit;
        logic    rd;
        t_idx_op idx_op;
        t_wr_op  wr_op;
        t_res_op res_op;
        t_status res_status;
        t_cnt_op cnt_op;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  slot_bad;
        logic  ge;
        logic  eq;
        logic  idx_zero;
        logic  idx_last;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ src/sorted_record_table.sv @@
`default_nettype none

// Channel   Dir  Word                                   Side info
// s_axis    in   key_hi,key_mid,key_lo,age_in,          tuser: func
//                phone_in_hi,phone_in_lo,slot
// m_axis    out  found_slot,entries,name_out_hi/mid/lo, tuser: status
//                age_out,phone_out_hi,phone_out_lo
//
// One word at a time. Insert at position pos moves every entry from pos up by one, with one
// memory read and one write per entry moved; delete moves the entries above slot down, and
// find scans from the first entry to a match or the last entry. Reset clears the record
// count, state and output valid, not the record memory; no clearing pass. A new word
// is taken while a result waits on m_axis; the next result then holds until m_axis_tready.

module sorted_record_table
    import srt_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // key_hi, key_mid, key_lo, age_in, phone_in_hi, phone_in_lo, slot
    input  wire logic [303:0] s_axis_tdata,
    // func
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // found_slot, entries, name_out_hi, name_out_mid, name_out_lo, age_out,
    // phone_out_hi, phone_out_lo
    output logic [311:0]      m_axis_tdata,
    // status
    output logic [1:0]        m_axis_tuser
);

    t_cmd       cmd;
    t_dp_stat   stat;
    t_rec       in_rec, out_rec;
    t_status    out_status;
    logic [7:0] out_pos, out_entries;

    assign in_rec.name_hi  = s_axis_tdata[63:0];
    assign in_rec.name_mid = s_axis_tdata[127:64];
    assign in_rec.name_lo  = s_axis_tdata[151:128];
    assign in_rec.age      = s_axis_tdata[183:152];
    assign in_rec.phone_hi = s_axis_tdata[247:184];
    assign in_rec.phone_lo = s_axis_tdata[295:248];

    srt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (t_func'(s_axis_tuser)),
        .i_rec        (in_rec),
        .i_slot       (s_axis_tdata[303:296]),
        .o_stat       (stat),
        .o_status     (out_status),
        .o_found_slot (out_pos),
        .o_entries    (out_entries),
        .o_rec        (out_rec)
    );

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {out_rec.phone_lo, out_rec.phone_hi, out_rec.age,
                           out_rec.name_lo, out_rec.name_mid, out_rec.name_hi,
                           out_entries, out_pos};

endmodule

`default_nettype wire

@@ src/srt_ctrl.sv @@
`default_nettype none

module srt_ctrl
    import srt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire logic     i_m_tready,
    output logic          o_m_tvalid,
    input  wire t_dp_stat i_stat,
    output t_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS,
        S_INS0,
        S_FETCH,
        S_DEL,
        S_FIND,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;

    always_comb begin
        cmd            = '0;
        cmd.idx_op     = IDX_HOLD;
        cmd.wr_op      = WR_NONE;
        cmd.res_op     = RES_NONE;
        cmd.res_status = ST_OK;
        cmd.cnt_op     = CNT_HOLD;
        n_state        = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.func)
                    FN_INSERT: begin
                        if (i_stat.full) begin
                            cmd.res_op     = RES_ERR;
                            cmd.res_status = ST_FULL;
                            n_state        = S_DONE;
                        end else if (i_stat.empty) begin
                            cmd.wr_op  = WR_NEW_0;
                            cmd.res_op = RES_NEW_0;
                            cmd.cnt_op = CNT_INC;
                            n_state    = S_DONE;
                        end else begin
                            cmd.idx_op = IDX_TOP;
                            cmd.rd     = 1'b1;
                            n_state    = S_INS;
                        end
                    end
                    FN_DELETE, FN_READ: begin
                        if (i_stat.slot_bad) begin
                            cmd.res_op     = RES_ERR;
                            cmd.res_status = ST_BADPOS;
                            n_state        = S_DONE;
                        end else begin
                            cmd.idx_op = IDX_SLOT;
                            cmd.rd     = 1'b1;
                            n_state    = S_FETCH;
                        end
                    end
                    FN_FIND: begin
                        if (i_stat.empty) begin
                            cmd.res_op     = RES_ERR;
                            cmd.res_status = ST_NOTFOUND;
                            n_state        = S_DONE;
                        end else begin
                            cmd.idx_op = IDX_ZERO;
                            cmd.rd     = 1'b1;
                            n_state    = S_FIND;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            // walk down from the top, moving up every entry not below the new name
            S_INS: begin
                if (i_stat.ge) begin
                    cmd.wr_op = WR_UP;
                    if (i_stat.idx_zero) begin
                        n_state = S_INS0;
                    end else begin
                        cmd.idx_op = IDX_DEC;
                        cmd.rd     = 1'b1;
                    end
                end else begin
                    cmd.wr_op  = WR_NEW_UP;
                    cmd.res_op = RES_NEW_UP;
                    cmd.cnt_op = CNT_INC;
                    n_state    = S_DONE;
                end
            end
            S_INS0: begin
                cmd.wr_op  = WR_NEW_0;
                cmd.res_op = RES_NEW_0;
                cmd.cnt_op = CNT_INC;
                n_state    = S_DONE;
            end
            S_FETCH: begin
                cmd.res_op = RES_HERE;
                if (i_stat.func == FN_READ) begin
                    n_state = S_DONE;
                end else if (i_stat.idx_last) begin
                    cmd.cnt_op = CNT_DEC;
                    n_state    = S_DONE;
                end else begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd     = 1'b1;
                    n_state    = S_DEL;
                end
            end
            S_DEL: begin
                cmd.wr_op = WR_DOWN;
                if (i_stat.idx_last) begin
                    cmd.cnt_op = CNT_DEC;
                    n_state    = S_DONE;
                end else begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd     = 1'b1;
                end
            end
            S_FIND: begin
                if (i_stat.eq) begin
                    cmd.res_op = RES_HERE;
                    n_state    = S_DONE;
                end else if (i_stat.idx_last) begin
                    cmd.res_op     = RES_ERR;
                    cmd.res_status = ST_NOTFOUND;
                    n_state        = S_DONE;
                end else begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd     = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/srt_dp.sv @@
`default_nettype none

module srt_dp
    import srt_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire t_func      i_func,
    input  wire t_rec       i_rec,
    input  wire logic [7:0] i_slot,
    output t_dp_stat        o_stat,
    output t_status         o_status,
    output logic [7:0]      o_found_slot,
    output logic [7:0]      o_entries,
    output t_rec            o_rec
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int PW   = (CNTW > 8) ? CNTW : 8;

    t_rec            mem [CAPACITY];
    t_rec            r_rd;
    t_rec            r_in;
    t_func           r_func;
    logic [7:0]      r_slot;
    logic [CNTW-1:0] r_count;
    logic [IW-1:0]   r_idx, n_idx;

    t_rec            r_res_rec;
    t_status         r_res_status;
    logic [7:0]      r_res_pos;

    t_rec            r_out_rec;
    t_status         r_out_status;
    logic [7:0]      r_out_pos;
    logic [7:0]      r_out_entries;

    logic            we;
    logic [IW-1:0]   wr_addr;
    t_rec            wr_data;
    logic [PW-1:0]   slot_w, count_w, idx_w;
    logic [PW-1:0]   top_w, slot_m1_w, pos_up_w, pos_here_w;
    logic [151:0]    rd_name, key_name;

    assign slot_w     = PW'(r_slot);
    assign count_w    = PW'(r_count);
    assign idx_w      = PW'(r_idx);
    assign top_w      = count_w - PW'(1);
    assign slot_m1_w  = slot_w - PW'(1);
    assign pos_up_w   = idx_w + PW'(2);
    assign pos_here_w = idx_w + PW'(1);
    assign rd_name    = {r_rd.name_hi, r_rd.name_mid, r_rd.name_lo};
    assign key_name   = {r_in.name_hi, r_in.name_mid, r_in.name_lo};

    always_comb begin
        o_stat.func     = r_func;
        o_stat.full     = (r_count == CNTW'(CAPACITY));
        o_stat.empty    = (r_count == '0);
        o_stat.slot_bad = (r_slot == '0) || (slot_w > count_w);
        o_stat.ge       = (rd_name >= key_name);
        o_stat.eq       = (rd_name == key_name);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_last = (pos_here_w == count_w);
    end

    always_comb begin
        unique case (i_cmd.idx_op)
            IDX_HOLD: n_idx = r_idx;
            IDX_TOP:  n_idx = top_w[IW-1:0];
            IDX_SLOT: n_idx = slot_m1_w[IW-1:0];
            IDX_ZERO: n_idx = '0;
            IDX_INC:  n_idx = r_idx + IW'(1);
            IDX_DEC:  n_idx = r_idx - IW'(1);
            default:  n_idx = r_idx;
        endcase
    end

    always_comb begin
        we      = 1'b0;
        wr_addr = r_idx;
        wr_data = r_rd;
        unique case (i_cmd.wr_op)
            WR_NONE: ;
            WR_UP: begin
                we      = 1'b1;
                wr_addr = r_idx + IW'(1);
            end
            WR_DOWN: begin
                we      = 1'b1;
                wr_addr = r_idx - IW'(1);
            end
            WR_NEW_UP: begin
                we      = 1'b1;
                wr_addr = r_idx + IW'(1);
                wr_data = r_in;
            end
            WR_NEW_0: begin
                we      = 1'b1;
                wr_addr = '0;
                wr_data = r_in;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_in   <= i_rec;
            r_slot <= i_slot;
        end
        r_idx <= n_idx;
        unique case (i_cmd.res_op)
            RES_NONE: ;
            RES_NEW_UP: begin
                r_res_rec    <= r_in;
                r_res_status <= ST_OK;
                r_res_pos    <= pos_up_w[7:0];
            end
            RES_NEW_0: begin
                r_res_rec    <= r_in;
                r_res_status <= ST_OK;
                r_res_pos    <= 8'd1;
            end
            RES_HERE: begin
                r_res_rec    <= r_rd;
                r_res_status <= ST_OK;
                r_res_pos    <= pos_here_w[7:0];
            end
            RES_ERR: begin
                r_res_rec    <= '0;
                r_res_status <= i_cmd.res_status;
                r_res_pos    <= '0;
            end
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_out_rec     <= r_res_rec;
            r_out_status  <= r_res_status;
            r_out_pos     <= r_res_pos;
            r_out_entries <= count_w[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case (i_cmd.cnt_op)
                CNT_HOLD: ;
                CNT_INC:  r_count <= r_count + CNTW'(1);
                CNT_DEC:  r_count <= r_count - CNTW'(1);
                default:  ;
            endcase
        end
    end

    assign o_status     = r_out_status;
    assign o_found_slot = r_out_pos;
    assign o_entries    = r_out_entries;
    assign o_rec        = r_out_rec;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_w <= PW'(CAPACITY))
        else $error("record count above capacity");

    a_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && i_cmd.rd) |-> (wr_addr != n_idx))
        else $error("read and write at one address");

    a_inc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_op == CNT_INC) |-> (r_count != CNTW'(CAPACITY)))
        else $error("insert into full table");

    a_dec_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_op == CNT_DEC) |-> (r_count != '0))
        else $error("delete from empty table");

    a_write_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (PW'(wr_addr) <= count_w))
        else $error("write beyond the filled part");
`endif

endmodule

`default_nettype wire
